>>> hdl/iva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package iva_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = 7;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpMod = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegOperation  = 2'd0,
    RegIsSigned   = 2'd1,
    RegWidthCode  = 2'd2,
    RegScalarMode = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
    logic finish;
    logic out_taken;
  } cmd_t;

  typedef struct packed {
    logic needs_mul;
    logic needs_div;
    logic iter_done;
  } stat_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       is_signed;
    logic [1:0] width_code;
    logic [1:0] scalar_mode;
  } cfg_t;
endpackage
`default_nettype wire

>>> hdl/iva_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface iva_stream_if #(
  parameter int unsigned PayloadW = 1
);
  logic                valid;
  logic                ready;
  logic [PayloadW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/iva_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module iva_ctrl
  import iva_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StMul;
      end
      StMul: begin
        if (stat_i.needs_div) state_d = StDiv;
        else if (!stat_i.needs_mul || stat_i.iter_done) state_d = StOut;
      end
      StDiv: begin
        if (stat_i.iter_done) state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StMul: begin
        cmd_o.mul_step = stat_i.needs_mul && !stat_i.needs_div && !stat_i.iter_done;
        cmd_o.finish = !stat_i.needs_div && (!stat_i.needs_mul || stat_i.iter_done);
      end
      StDiv: begin
        cmd_o.div_step = !stat_i.iter_done;
        cmd_o.finish = stat_i.iter_done;
      end
      StOut: begin
        out_valid_o = 1'b1;
        cmd_o.out_taken = out_ready_i;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/iva_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module iva_datapath
  import iva_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  input  wire [DataW-1:0]   left_i,
  input  wire [DataW-1:0]   right_i,
  input  wire               null_i,
  input  wire               last_i,
  output stat_t             stat_o,
  output logic [DataW-1:0]  result_o,
  output logic              written_o,
  output logic [1:0]        status_o,
  output logic              last_o
);
  logic [DataW-1:0] mask_q, sb_q, a_q, b_q, am_q, bm_q, hold_q;
  logic [DataW-1:0] res_q, res_d;
  logic [1:0]       op_q;
  logic             sgn_q, an_q, bn_q, null_q, last_q, first_q;
  logic             ovf_q, dz_q, written_q;
  logic [CntW-1:0]  cnt_q;
  // Multiply: 64 shift-add steps into a 128-bit product.
  logic [2*DataW-1:0] prod_q;
  logic [DataW-1:0]   mplier_q;
  // Modulo: restoring division, one quotient bit per step.
  logic [DataW:0]     rem_q;
  logic [DataW-1:0]   dvd_q;

  logic [DataW-1:0] mask_d, sb_d, ain, bin, a_m, b_m, ax, bx;
  logic             an, bn, ovf_d, dz_d, wr_d;
  logic [DataW:0]   rem_sh, rem_sub;
  logic [DataW-1:0] lim;
  logic [DataW-1:0] scal;

  always_comb begin
    unique case (cfg_i.width_code)
      2'd0: mask_d = 64'h0000_0000_0000_00FF;
      2'd1: mask_d = 64'h0000_0000_0000_FFFF;
      2'd2: mask_d = 64'h0000_0000_FFFF_FFFF;
      default: mask_d = '1;
    endcase
    sb_d = mask_d ^ (mask_d >> 1);
    scal = first_q ? (cfg_i.scalar_mode[0] ? left_i : right_i) : hold_q;
    ain = cfg_i.scalar_mode[0] ? scal : left_i;
    bin = (!cfg_i.scalar_mode[0] && cfg_i.scalar_mode[1]) ? scal : right_i;
    ain = ain & mask_d;
    bin = bin & mask_d;
    an = cfg_i.is_signed && |(ain & sb_d);
    bn = cfg_i.is_signed && |(bin & sb_d);
    ax = an ? (ain | ~mask_d) : ain;
    bx = bn ? (bin | ~mask_d) : bin;
    a_m = an ? (~ax + 64'd1) : ax;
    b_m = bn ? (~bx + 64'd1) : bx;
  end

  assign rem_sh  = {rem_q[DataW-1:0], dvd_q[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, bm_q};

  always_comb begin
    if (!sgn_q) lim = mask_q;
    else if (an_q != bn_q) lim = (mask_q >> 1) + 64'd1;
    else lim = mask_q >> 1;
  end

  assign stat_o.needs_mul = (op_q == OpMul) && !null_q;
  assign stat_o.needs_div = (op_q == OpMod) && !null_q && (b_q != '0) && !cmd_i.div_step
                            && (cnt_q == '0) && !rem_q[DataW];
  assign stat_o.iter_done = cnt_q == CntW'(DataW);

  always_comb begin
    res_d = '0;
    ovf_d = 1'b0;
    dz_d = 1'b0;
    wr_d = !null_q;
    unique case (op_q)
      OpAdd: begin
        res_d = (a_q + b_q) & mask_q;
        ovf_d = sgn_q ? |((res_d ^ a_q) & (res_d ^ b_q) & sb_q) : (res_d < a_q);
      end
      OpSub: begin
        res_d = (a_q - b_q) & mask_q;
        ovf_d = sgn_q ? |((a_q ^ b_q) & (res_d ^ a_q) & sb_q) : (a_q < b_q);
      end
      OpMul: begin
        res_d = (an_q != bn_q) ? ((~prod_q[DataW-1:0] + 64'd1) & mask_q)
                               : (prod_q[DataW-1:0] & mask_q);
        ovf_d = (prod_q[2*DataW-1:DataW] != '0) || (prod_q[DataW-1:0] > lim);
      end
      OpMod: begin
        if (b_q == '0) begin
          wr_d = 1'b0;
          dz_d = 1'b1;
        end else begin
          res_d = (an_q ? (~rem_q[DataW-1:0] + 64'd1) : rem_q[DataW-1:0]) & mask_q;
        end
      end
      default: ;
    endcase
    if (null_q) begin
      ovf_d = 1'b0;
      dz_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hold_q <= scal;
      mask_q <= mask_d;
      sb_q <= sb_d;
      a_q <= ain;
      b_q <= bin;
      am_q <= a_m;
      bm_q <= b_m;
      an_q <= an;
      bn_q <= bn;
      sgn_q <= cfg_i.is_signed;
      op_q <= cfg_i.operation;
      null_q <= null_i;
      last_q <= last_i;
      prod_q <= '0;
      mplier_q <= b_m;
      rem_q <= '0;
      dvd_q <= a_m;
    end
    if (cmd_i.mul_step) begin
      prod_q <= prod_q + (mplier_q[DataW-1] ? ({{DataW{1'b0}}, am_q} << (DataW - 1 - cnt_q))
                                            : '0);
      mplier_q <= mplier_q << 1;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_sub[DataW] ? rem_sh : rem_sub;
      dvd_q <= dvd_q << 1;
    end
    if (cmd_i.finish) begin
      res_q <= wr_d ? res_d : '0;
      written_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      first_q <= 1'b1;
      ovf_q <= 1'b0;
      dz_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
        first_q <= 1'b0;
      end else if (cmd_i.mul_step || cmd_i.div_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.finish) begin
        ovf_q <= ovf_q | ovf_d;
        dz_q <= dz_q | dz_d;
      end
      if (cmd_i.out_taken && last_q) begin
        ovf_q <= 1'b0;
        dz_q <= 1'b0;
        first_q <= 1'b1;
      end
    end
  end

  assign result_o = res_q;
  assign written_o = written_q;
  assign status_o = dz_q ? 2'd2 : (ovf_q ? 2'd1 : 2'd0);
  assign last_o = last_q;
endmodule
`default_nettype wire

>>> hdl/integer_vector_arith_overflow.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload
// in_if     sink       left_value, right_value, is_null, last
// out_if    source     result_value, written, status, last_out
// cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
// Add, subtract, null items and modulo by zero finish without iterating; multiply
// runs the 64-step shift-add multiplier and modulo the 64-step radix-2 restoring
// divider. A new item is taken only after the previous result has been taken.
// The result waits in its output register until the transfer completes.
// Reset is asynchronous and active low; it clears the sticky status.
module integer_vector_arith_overflow
  import iva_pkg::*;
(
  input wire          clk_i,
  input wire          rst_ni,
  input wire          cfg_we_i,
  input wire [1:0]    cfg_idx_i,
  input wire [1:0]    cfg_data_i,
  iva_stream_if.sink   in_if,
  iva_stream_if.source out_if
);
  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic [DataW-1:0] res;
  logic written, last_o;
  logic [1:0] status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{operation: 2'd0, is_signed: 1'b1, width_code: 2'd3, scalar_mode: 2'd0};
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        RegOperation:  cfg_q.operation <= cfg_data_i;
        RegIsSigned:   cfg_q.is_signed <= cfg_data_i[0];
        RegWidthCode:  cfg_q.width_code <= cfg_data_i;
        RegScalarMode: cfg_q.scalar_mode <= cfg_data_i;
        default: ;
      endcase
    end
  end

  iva_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  iva_datapath u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_i(cmd),
    .left_i(in_if.data[129:66]), .right_i(in_if.data[65:2]),
    .null_i(in_if.data[1]), .last_i(in_if.data[0]),
    .stat_o(stat), .result_o(res), .written_o(written),
    .status_o(status), .last_o(last_o)
  );

  assign out_if.data = {res, written, status, last_o};

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid)) else $error("input taken while result pending");
  a_unwritten_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !written |-> res == '0) else $error("unwritten result not zero");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status != 2'd3) else $error("bad status");
endmodule
`default_nettype wire

>>> sim/tb_integer_vector_arith_overflow.sv
`timescale 1ns / 1ps
module tb_integer_vector_arith_overflow;
  import iva_pkg::*;

  typedef struct packed {
    logic [63:0] left_value;
    logic [63:0] right_value;
    logic        is_null;
    logic        last;
  } operand_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        written;
    logic [1:0]  status;
    logic        last_out;
  } result_t;

  typedef struct {
    op_e         op;
    logic        sgn;
    logic [1:0]  wc;
    logic [1:0]  sm;
    logic [63:0] left_value;
    logic [63:0] right_value;
    logic        is_null;
    logic        last;
    bit          typed;
    result_t     res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = RegOperation;
  logic [1:0] cfg_data_i = 2'd0;

  iva_stream_if #(.PayloadW($bits(operand_t))) in_ch ();
  iva_stream_if #(.PayloadW($bits(result_t))) out_ch ();

  integer_vector_arith_overflow u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  op_e        cur_op = OpAdd;
  logic       cur_sgn = 1'b1;
  logic [1:0] cur_wc = 2'd3;
  logic [1:0] cur_sm = 2'd0;
  bit         ovf_flag = 1'b0;
  bit         dz_flag = 1'b0;
  bit         first_elem = 1'b1;
  logic [63:0] scalar_val = '0;

  result_t pending_results[$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      failed = 1'b0;
  int      quiet_cycles = 0;

  task automatic compute_result(input operand_t it, output result_t r);
    int unsigned w;
    logic [63:0] mask, sb, a, b, ax, bx, am, bm, res, lim, rem;
    logic [127:0] prod;
    bit an, bn, ovf, wr;
    w = 8 << cur_wc;
    mask = (w == 64) ? '1 : ((64'd1 << w) - 1);
    sb = 64'd1 << (w - 1);
    a = it.left_value;
    b = it.right_value;
    res = '0;
    wr = 1'b0;
    ovf = 1'b0;
    if (first_elem) begin
      scalar_val = cur_sm[0] ? a : b;
      first_elem = 1'b0;
    end
    if (cur_sm[0]) a = scalar_val;
    else if (cur_sm[1]) b = scalar_val;
    a &= mask;
    b &= mask;
    if (!it.is_null) begin
      an = cur_sgn && ((a & sb) != 0);
      bn = cur_sgn && ((b & sb) != 0);
      ax = an ? (a | ~mask) : a;
      bx = bn ? (b | ~mask) : b;
      am = an ? -ax : ax;
      bm = bn ? -bx : bx;
      wr = 1'b1;
      case (cur_op)
        OpAdd: begin
          res = (a + b) & mask;
          ovf = cur_sgn ? (((res ^ a) & (res ^ b) & sb) != 0) : (res < a);
        end
        OpSub: begin
          res = (a - b) & mask;
          ovf = cur_sgn ? (((a ^ b) & (res ^ a) & sb) != 0) : (a < b);
        end
        OpMul: begin
          res = (a * b) & mask;
          prod = {64'd0, am} * {64'd0, bm};
          if (!cur_sgn) lim = mask;
          else if (an != bn) lim = (mask >> 1) + 1;
          else lim = mask >> 1;
          ovf = prod > {64'd0, lim};
        end
        default: begin
          if (b == 0) begin
            wr = 1'b0;
            dz_flag = 1'b1;
          end else begin
            rem = am % bm;
            res = (an ? -rem : rem) & mask;
          end
        end
      endcase
      if (ovf) ovf_flag = 1'b1;
    end
    r.result_value = wr ? res : '0;
    r.written = wr;
    r.status = dz_flag ? 2'd2 : (ovf_flag ? 2'd1 : 2'd0);
    r.last_out = it.last;
    if (it.last) begin
      ovf_flag = 1'b0;
      dz_flag = 1'b0;
      first_elem = 1'b1;
    end
  endtask

  // Registers change only when no transfer is outstanding and the datapath has drained.
  task automatic set_config(input op_e op, input logic sgn, input logic [1:0] wc,
                            input logic [1:0] sm);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegOperation;
    cfg_data_i <= op;
    @(posedge clk_i);
    cfg_idx_i <= RegIsSigned;
    cfg_data_i <= {1'b0, sgn};
    @(posedge clk_i);
    cfg_idx_i <= RegWidthCode;
    cfg_data_i <= wc;
    @(posedge clk_i);
    cfg_idx_i <= RegScalarMode;
    cfg_data_i <= sm;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_op = op;
    cur_sgn = sgn;
    cur_wc = wc;
    cur_sm = sm;
  endtask

  task automatic send_operand(input operand_t it, input bit typed, input result_t typed_res);
    result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    compute_result(it, r);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'(1) << $urandom_range(0, 63);
      3: return 64'($urandom_range(0, 15));
      4: return {$urandom, $urandom} | (64'(1) << $urandom_range(0, 63));
      5: return {56'd0, 8'h80} << (8 * $urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: %h", got);
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (got.result_value !== want.result_value) begin
            $error("result_value expected %h actual %h", want.result_value, got.result_value);
            failed = 1'b1;
          end
          if (got.written !== want.written) begin
            $error("written expected %b actual %b", want.written, got.written);
            failed = 1'b1;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            failed = 1'b1;
          end
          if (got.last_out !== want.last_out) begin
            $error("last_out expected %b actual %b", want.last_out, got.last_out);
            failed = 1'b1;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  row_t directed[$];

  function automatic row_t mk(op_e op, logic sgn, logic [1:0] wc, logic [1:0] sm,
                              logic [63:0] l, logic [63:0] r, logic nul, logic lst,
                              bit typed, logic [63:0] v, logic wr, logic [1:0] st);
    row_t x;
    x.op = op; x.sgn = sgn; x.wc = wc; x.sm = sm;
    x.left_value = l; x.right_value = r; x.is_null = nul; x.last = lst;
    x.typed = typed;
    x.res = '{result_value: v, written: wr, status: st, last_out: lst};
    return x;
  endfunction

  initial begin
    operand_t it;
    row_t rw;
    int n_items;
    int vlen;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    directed.push_back(mk(OpAdd, 1, 3, 0, 64'd1, 64'd2, 0, 1, 1, 64'd3, 1, 0));
    directed.push_back(mk(OpAdd, 1, 3, 0, 64'h7fff_ffff_ffff_ffff, 64'd1, 0, 1, 1,
                          64'h8000_0000_0000_0000, 1, 1));
    directed.push_back(mk(OpAdd, 0, 0, 0, 64'hff, 64'h1, 0, 1, 1, 64'h0, 1, 1));
    directed.push_back(mk(OpAdd, 0, 0, 0, '1, '1, 0, 1, 1, 64'hfe, 1, 1));
    directed.push_back(mk(OpSub, 1, 2, 0, 64'h8000_0000, 64'd1, 0, 1, 1,
                          64'h7fff_ffff, 1, 1));
    directed.push_back(mk(OpSub, 0, 2, 0, 64'd0, 64'd1, 0, 1, 1, 64'hffff_ffff, 1, 1));
    directed.push_back(mk(OpMul, 1, 1, 0, 64'h100, 64'h100, 0, 1, 1, 64'h0, 1, 1));
    directed.push_back(mk(OpMul, 1, 0, 0, 64'h80, 64'hff, 0, 1, 1, 64'h80, 1, 1));
    directed.push_back(mk(OpMul, 1, 0, 0, 64'h80, 64'h01, 0, 1, 1, 64'h80, 1, 0));
    directed.push_back(mk(OpMul, 0, 3, 0, '1, '1, 0, 1, 1, 64'd1, 1, 1));
    directed.push_back(mk(OpMod, 1, 3, 0, 64'h8000_0000_0000_0000, '1, 0, 1, 1, 0, 1, 0));
    directed.push_back(mk(OpMod, 0, 2, 0, 64'd7, 64'h1_0000_0000, 0, 1, 1, 0, 0, 2));
    directed.push_back(mk(OpMod, 1, 0, 0, 64'hf9, 64'd2, 0, 1, 1, 64'hff, 1, 0));
    directed.push_back(mk(OpMod, 1, 0, 0, 64'hf9, 64'd2, 1, 1, 1, 64'h0, 0, 0));
    // Overflow followed by a zero divisor in one vector must report division by zero.
    directed.push_back(mk(OpMul, 1, 0, 0, 64'h7f, 64'h2, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpMod, 1, 0, 0, 64'd9, 64'd0, 0, 1, 1, 0, 0, 2));
    directed.push_back(mk(OpMod, 1, 0, 1, 64'd0, 64'd5, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpMod, 1, 0, 1, 64'd9, 64'd5, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk(OpMul, 0, 1, 2, 64'h1234, 64'h100, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpMul, 0, 1, 2, 64'h1000, 64'h7, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpMul, 0, 1, 2, 64'h3, 64'h9, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk(OpSub, 1, 1, 3, 64'h8000, 64'h1, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OpSub, 1, 1, 3, 64'h5, 64'h2, 0, 1, 0, 0, 0, 0));

    send_idle_pct = 36;
    recv_idle_pct = 76;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      rw = directed[i];
      if (rw.op != cur_op || rw.sgn != cur_sgn || rw.wc != cur_wc || rw.sm != cur_sm) begin
        in_ch.valid <= 1'b0;
        set_config(rw.op, rw.sgn, rw.wc, rw.sm);
      end
      it = '{left_value: rw.left_value, right_value: rw.right_value,
             is_null: rw.is_null, last: rw.last};
      send_operand(it, rw.typed, rw.res);
    end

    n_items = 0;
    while (n_items < 1000) begin
      if (n_items >= 660) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n_items >= 330) begin
        send_idle_pct = 76;
        recv_idle_pct = 36;
      end
      if ($urandom_range(0, 3) == 0) begin
        in_ch.valid <= 1'b0;
        set_config(op_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end
      vlen = $urandom_range(1, 8);
      for (int k = 0; k < vlen; k++) begin
        it.left_value = pick_value();
        it.right_value = pick_value();
        it.is_null = ($urandom_range(0, 9) == 0);
        it.last = (k == vlen - 1);
        send_operand(it, 1'b0, '0);
        n_items++;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> integer_vector_arith_overflow.f
hdl/iva_pkg.sv
hdl/iva_stream_if.sv
hdl/iva_ctrl.sv
hdl/iva_datapath.sv
hdl/integer_vector_arith_overflow.sv
sim/tb_integer_vector_arith_overflow.sv
